// File: design/fcst_pkg.sv
// fcst_pkg: shared types, codes and default sizes of the set table.
// Used by the channel interfaces, the sequencer, the entry store and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcst_pkg;

  // payload widths of the channels
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // default sizes handed to the top level
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned ITEM_WIDTH_DEF = 32;

  // request opcodes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // store port strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

// File: design/fcst_req_if.sv
// fcst_req_if: request channel (valid/ready with opcode and item value).
// Depends on fcst_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface fcst_req_if;
  logic                        valid;
  logic                        ready;
  logic [fcst_pkg::CMD_W-1:0]  cmd;
  logic [fcst_pkg::ITEM_W-1:0] item;

  modport source (output valid, output cmd, output item, input ready);
  modport sink   (input valid, input cmd, input item, output ready);
endinterface

`default_nettype wire

// File: design/fcst_rsp_if.sv
// fcst_rsp_if: response channel (valid/ready with ok, status and count).
// Depends on fcst_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface fcst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [fcst_pkg::STATUS_W-1:0] status;
  logic [fcst_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output ok, output status, output count, input ready);
  modport sink   (input valid, input ok, input status, input count, output ready);
endinterface

`default_nettype wire

// File: design/fcst_store.sv
// fcst_store: entry memory of the set table, one write and one registered read per cycle.
// Depends on fcst_pkg (mem_ctl_t).
`timescale 1ns / 1ps
`default_nettype none

module fcst_store #(
  parameter int unsigned CAPACITY   = fcst_pkg::CAPACITY_DEF,
  parameter int unsigned ITEM_WIDTH = fcst_pkg::ITEM_WIDTH_DEF,
  localparam int unsigned AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                  clk_i,
  input  wire fcst_pkg::mem_ctl_t    ctl_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [ITEM_WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]         raddr_i,
  output logic      [ITEM_WIDTH-1:0] rdata_o
);

  logic [ITEM_WIDTH-1:0] mem [CAPACITY];
  logic [ITEM_WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/fcst_seq.sv
// fcst_seq: request sequencer of the set table: linear scan with one shared comparator,
// fill count, swap-with-last removal and the response register.
// Depends on fcst_pkg, fcst_req_if, fcst_rsp_if; drives the fcst_store ports.
`timescale 1ns / 1ps
`default_nettype none

module fcst_seq #(
  parameter int unsigned CAPACITY   = fcst_pkg::CAPACITY_DEF,
  parameter int unsigned ITEM_WIDTH = fcst_pkg::ITEM_WIDTH_DEF,
  localparam int unsigned AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW        = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  fcst_req_if.sink                   req_i,
  fcst_rsp_if.source                 rsp_o,
  output fcst_pkg::mem_ctl_t         mem_ctl_o,
  output logic      [AW-1:0]         mem_waddr_o,
  output logic      [ITEM_WIDTH-1:0] mem_wdata_o,
  output logic      [AW-1:0]         mem_raddr_o,
  input  wire logic [ITEM_WIDTH-1:0] mem_rdata_i
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MVRD = 3'd2;
  localparam logic [2:0] S_MVWR = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  logic [2:0]             state_q, state_d;
  logic [CW-1:0]          fill_q, fill_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic                   pend_q, pend_d;
  logic [AW-1:0]          cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]          slot_q, slot_d;
  fcst_pkg::cmd_e         cmd_q, cmd_d;
  logic [ITEM_WIDTH-1:0]  key_q, key_d;
  logic                   res_ok_q, res_ok_d;
  fcst_pkg::status_e      res_st_q, res_st_d;
  logic                   out_vld_q, out_vld_d;
  logic                   out_ok_q, out_ok_d;
  fcst_pkg::status_e      out_st_q, out_st_d;
  logic [fcst_pkg::COUNT_W-1:0] out_cnt_q, out_cnt_d;

  logic hit;
  logic more;
  logic out_free;

  // shared comparator on the entry just read
  assign hit      = pend_q && (mem_rdata_i == key_q);
  assign more     = idx_q < fill_q;
  assign out_free = !out_vld_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);

  // store address and data selection
  assign mem_raddr_o = (state_q == S_MVRD) ? AW'(fill_q - ONE_CNT) : idx_q[AW-1:0];
  assign mem_waddr_o = (state_q == S_MVWR) ? slot_q : fill_q[AW-1:0];
  assign mem_wdata_o = (state_q == S_MVWR) ? mem_rdata_i : key_q;

  // sequencer
  always_comb begin
    state_d          = state_q;
    fill_d           = fill_q;
    idx_d            = idx_q;
    pend_d           = 1'b0;
    cmp_idx_d        = cmp_idx_q;
    slot_d           = slot_q;
    cmd_d            = cmd_q;
    key_d            = key_q;
    res_ok_d         = res_ok_q;
    res_st_d         = res_st_q;
    mem_ctl_o.rd_en  = 1'b0;
    mem_ctl_o.wr_en  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_d = fcst_pkg::cmd_e'(req_i.cmd);
          key_d = ITEM_WIDTH'(req_i.item);
          idx_d = '0;
          if (fcst_pkg::cmd_e'(req_i.cmd) == fcst_pkg::CMD_CLEAR) begin
            fill_d   = '0;
            res_ok_d = 1'b1;
            res_st_d = fcst_pkg::ST_DONE;
            state_d  = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          // item is held at cmp_idx_q
          unique case (cmd_q)
            fcst_pkg::CMD_ADD: begin
              res_ok_d = 1'b0;
              res_st_d = fcst_pkg::ST_DUP;
              state_d  = S_DONE;
            end
            fcst_pkg::CMD_REMOVE: begin
              slot_d  = cmp_idx_q;
              state_d = S_MVRD;
            end
            default: begin
              res_ok_d = 1'b1;
              res_st_d = fcst_pkg::ST_DONE;
              state_d  = S_DONE;
            end
          endcase
        end else if (!more) begin
          // scan exhausted, item absent
          state_d = S_DONE;
          if (cmd_q == fcst_pkg::CMD_ADD) begin
            if (fill_q >= FULL_CNT) begin
              res_ok_d = 1'b0;
              res_st_d = fcst_pkg::ST_FULL;
            end else begin
              mem_ctl_o.wr_en = 1'b1;
              fill_d          = fill_q + ONE_CNT;
              res_ok_d        = 1'b1;
              res_st_d        = fcst_pkg::ST_DONE;
            end
          end else begin
            res_ok_d = 1'b0;
            res_st_d = fcst_pkg::ST_MISSING;
          end
        end else begin
          // fetch the next filled entry
          mem_ctl_o.rd_en = 1'b1;
          pend_d          = 1'b1;
          cmp_idx_d       = idx_q[AW-1:0];
          idx_d           = idx_q + ONE_CNT;
        end
      end
      S_MVRD: begin
        mem_ctl_o.rd_en = 1'b1;
        state_d         = S_MVWR;
      end
      S_MVWR: begin
        // last entry fills the freed slot
        mem_ctl_o.wr_en = 1'b1;
        fill_d          = fill_q - ONE_CNT;
        res_ok_d        = 1'b1;
        res_st_d        = fcst_pkg::ST_DONE;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // response register
  always_comb begin
    out_vld_d = out_vld_q;
    out_ok_d  = out_ok_q;
    out_st_d  = out_st_q;
    out_cnt_d = out_cnt_q;
    if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (state_q == S_DONE && out_free) begin
      out_vld_d = 1'b1;
      out_ok_d  = res_ok_q;
      out_st_d  = res_st_q;
      out_cnt_d = fcst_pkg::COUNT_W'(fill_q);
    end
  end

  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.ok     = out_ok_q;
  assign rsp_o.status = out_st_q;
  assign rsp_o.count  = out_cnt_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      idx_q     <= idx_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    res_ok_q  <= res_ok_d;
    res_st_q  <= res_st_d;
    out_ok_q  <= out_ok_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
  end

endmodule

`default_nettype wire

// File: design/fixed_capacity_set_table.sv
// fixed_capacity_set_table: top level of the set table.
// Depends on fcst_pkg, fcst_req_if, fcst_rsp_if, fcst_store and fcst_seq.
//
// Usage:
//   req_i carries one request per transaction: cmd (add, remove, contains,
//   clear) and item. rsp_o returns exactly one transaction per request with
//   ok, status and the entry count after the request.
//   Entries sit in a single-port-read memory; the sequencer reads one filled
//   entry per cycle and tests it on one shared comparator, stopping at the
//   first match or at the fill count. A remove that hits then moves the last
//   entry into the freed slot (S_MVRD reads it, S_MVWR writes it). A clear
//   skips the scan. req_i.ready is high only between requests, so a new
//   request is accepted only after the last one has left the sequencer.
//   The response sits in an output register; the next request is accepted
//   while it waits. If rsp_o is stalled when a second result is done, the
//   sequencer holds that result and stays busy until the register frees.
//   Reset (rst_ni low, asynchronous) empties the table at once: no clearing
//   pass, entries beyond the fill count are never read.
`timescale 1ns / 1ps
`default_nettype none

module fixed_capacity_set_table #(
  parameter int unsigned CAPACITY   = fcst_pkg::CAPACITY_DEF,
  parameter int unsigned ITEM_WIDTH = fcst_pkg::ITEM_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fcst_req_if.sink   req_i,
  fcst_rsp_if.source rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  fcst_pkg::mem_ctl_t    mem_ctl;
  logic [AW-1:0]         mem_waddr;
  logic [ITEM_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_rdata;

  // sequencer and comparator
  fcst_seq #(
    .CAPACITY  (CAPACITY),
    .ITEM_WIDTH(ITEM_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .mem_ctl_o  (mem_ctl),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  // entry memory
  fcst_store #(
    .CAPACITY  (CAPACITY),
    .ITEM_WIDTH(ITEM_WIDTH)
  ) u_store (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

`default_nettype wire

// File: design/fcst_checker.sv
// fcst_checker: port-level assertions for the set table, bound to the top level.
// Depends on fcst_pkg and fixed_capacity_set_table.
`timescale 1ns / 1ps
`default_nettype none

module fcst_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic                          ok_i,
  input wire logic [fcst_pkg::STATUS_W-1:0] status_i,
  input wire logic [fcst_pkg::COUNT_W-1:0]  count_i
);

  logic [1:0] open_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // requests accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // a response never appears without an open request
  a_rsp_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (open_q != 2'd0))
    else $error("response without open request");

  // busy after accepting a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("request accepted while previous one in progress");

  // ok is set exactly for completed operations
  a_ok_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (ok_i == (status_i == fcst_pkg::ST_DONE)))
    else $error("ok disagrees with status");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(ok_i) && $stable(status_i) && $stable(count_i)))
    else $error("response payload changed while stalled");

endmodule

bind fixed_capacity_set_table fcst_checker u_fcst_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (req_i.valid),
  .in_ready_i (req_i.ready),
  .out_valid_i(rsp_o.valid),
  .out_ready_i(rsp_o.ready),
  .ok_i       (rsp_o.ok),
  .status_i   (rsp_o.status),
  .count_i    (rsp_o.count)
);

`default_nettype wire
